// ===== hdl/ascii_reading_stats_collector_top_macros.svh =====
`ifndef ASCII_READING_STATS_COLLECTOR_TOP_MACROS_SVH
`define ASCII_READING_STATS_COLLECTOR_TOP_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ARSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition that must never be seen outside reset
`define ARSC_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== hdl/arsc_pkg.sv =====
`default_nettype none

package arsc_pkg;

  localparam int NumBins = 20;
  localparam int BinW = (NumBins > 1) ? $clog2(NumBins) : 1;
  localparam logic [BinW-1:0] LastBin = BinW'(NumBins - 1);

  localparam int QueueDepth = 2;
  localparam int QPtrW = $clog2(QueueDepth);
  localparam int QCntW = $clog2(QueueDepth + 1);

  localparam int DivSteps = 32;
  localparam int DivCntW = $clog2(DivSteps);

  localparam logic OpByte = 1'b0;
  localparam logic OpRead = 1'b1;

  localparam logic [2:0] HdrLen       = 3'd3;
  localparam logic [2:0] PosDigitLast = 3'd6;
  localparam logic [7:0] HdrByte0     = 8'h6D;
  localparam logic [7:0] HdrByte1     = 8'h3A;
  localparam logic [7:0] HdrByte2     = 8'h20;
  localparam logic [15:0] AsciiZero   = 16'd48;
  localparam logic [15:0] DecBase     = 16'd10;
  localparam logic [31:0] MeanScale   = 32'd100;

  typedef enum logic {
    CMD_RECORD,
    CMD_READ
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e     op;
    logic [15:0] value;
  } cmd_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_MUL,
    BS_DIV,
    BS_EMIT
  } back_state_e;

endpackage

`default_nettype wire

// ===== hdl/arsc_front.sv =====
`default_nettype none

module arsc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           opcode_i,
  input  logic [7:0]     rx_byte_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output arsc_pkg::cmd_t cmd_o
);
  import arsc_pkg::*;

  logic [2:0]  pos_q, pos_d;
  logic [15:0] acc_q, acc_d;
  logic [15:0] digit, acc_x10, acc_next;
  logic [7:0]  hdr_byte;
  logic        accept;

  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i & cmd_ready_i;
  assign digit      = {8'd0, rx_byte_i} - AsciiZero;
  assign acc_x10    = acc_q * DecBase;
  assign acc_next   = (pos_q == HdrLen) ? digit : acc_x10 + digit;

  always_comb begin
    case (pos_q[1:0])
      2'd0:    hdr_byte = HdrByte0;
      2'd1:    hdr_byte = HdrByte1;
      2'd2:    hdr_byte = HdrByte2;
      default: hdr_byte = HdrByte0;
    endcase
  end

  always_comb begin
    pos_d       = pos_q;
    acc_d       = acc_q;
    cmd_valid_o = 1'b0;
    cmd_o.op    = CMD_RECORD;
    cmd_o.value = acc_next;
    if (accept) begin
      if (opcode_i == OpRead) begin
        cmd_valid_o = 1'b1;
        cmd_o.op    = CMD_READ;
      end else if (pos_q < HdrLen) begin
        pos_d = (rx_byte_i == hdr_byte) ? pos_q + 3'd1 : 3'd0;
      end else begin
        acc_d = acc_next;
        if (pos_q == PosDigitLast) begin
          pos_d       = 3'd0;
          cmd_valid_o = 1'b1;
        end else begin
          pos_d = pos_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 3'd0;
      acc_q <= 16'd0;
    end else begin
      pos_q <= pos_d;
      acc_q <= acc_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/arsc_queue.sv =====
`default_nettype none

module arsc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  arsc_pkg::cmd_t push_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output arsc_pkg::cmd_t pop_o
);
  import arsc_pkg::*;

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != QCntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/arsc_div.sv =====
`default_nettype none

module arsc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] quotient_o
);
  import arsc_pkg::*;

  logic [31:0]        quo_q;
  logic [15:0]        rem_q, dvs_q;
  logic [DivCntW-1:0] step_q;
  logic               busy_q, done_q;
  logic [16:0]        shifted, diff;
  logic               ge;

  assign shifted    = {rem_q, quo_q[31]};
  assign diff       = shifted - {1'b0, dvs_q};
  assign ge         = (shifted >= {1'b0, dvs_q});
  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= 16'd0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[30:0], ge};
      rem_q <= ge ? diff[15:0] : shifted[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == DivCntW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/arsc_back.sv =====
`default_nettype none

`include "ascii_reading_stats_collector_top_macros.svh"

module arsc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  arsc_pkg::cmd_t cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [31:0]    mean_x100_o,
  output logic           mean_valid_o,
  output logic [15:0]    sample_count_o,
  output logic [4:0]     bin_index_o,
  output logic [7:0]     bin_count_o,
  output logic           last_o
);
  import arsc_pkg::*;

  back_state_e     state_q, state_d;
  logic [31:0]     sum_q;
  logic [15:0]     count_q;
  logic [7:0]      bins_q [NumBins];
  logic [31:0]     num_q, mean_q;
  logic [15:0]     den_q;
  logic            den_pos_q, mean_valid_q;
  logic [BinW-1:0] idx_q, bin_sel;
  logic            out_valid_q;
  logic [31:0]     out_mean_q;
  logic            out_mean_valid_q, out_last_q;
  logic [15:0]     out_count_q;
  logic [4:0]      out_idx_q;
  logic [7:0]      out_bin_q;

  logic        rec, capture, clear, load_out, div_start;
  logic        div_busy, div_done;
  logic [31:0] div_quo;
  logic [16:0] den_full;
  logic        den_pos;

  assign den_full = {1'b0, count_q} - {9'd0, bins_q[0]};
  assign den_pos  = !den_full[16] && (den_full[15:0] != 16'd0);
  assign bin_sel  = (cmd_i.value < 16'(NumBins - 1)) ? cmd_i.value[BinW-1:0] : LastBin;

  arsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_q),
    .divisor_i  (den_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d     = state_q;
    cmd_ready_o = 1'b0;
    rec         = 1'b0;
    capture     = 1'b0;
    clear       = 1'b0;
    load_out    = 1'b0;
    div_start   = 1'b0;
    case (state_q)
      BS_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          if (cmd_i.op == CMD_RECORD) begin
            rec = 1'b1;
          end else begin
            capture = 1'b1;
            state_d = BS_MUL;
          end
        end
      end
      BS_MUL: begin
        if (den_pos_q) begin
          div_start = 1'b1;
          state_d   = BS_DIV;
        end else begin
          state_d = BS_EMIT;
        end
      end
      BS_DIV: begin
        if (div_done) begin
          state_d = BS_EMIT;
        end
      end
      BS_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          if (idx_q == LastBin) begin
            clear   = 1'b1;
            state_d = BS_IDLE;
          end
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      sum_q       <= 32'd0;
      count_q     <= 16'd0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumBins; i++) begin
        bins_q[i] <= 8'd0;
      end
    end else begin
      state_q <= state_d;
      if (clear) begin
        sum_q   <= 32'd0;
        count_q <= 16'd0;
      end else if (rec) begin
        sum_q   <= sum_q + {16'd0, cmd_i.value};
        count_q <= count_q + 16'd1;
      end
      for (int i = 0; i < NumBins; i++) begin
        if (clear) begin
          bins_q[i] <= 8'd0;
        end else if (rec && (bin_sel == BinW'(i))) begin
          bins_q[i] <= bins_q[i] + 8'd1;
        end
      end
      if (capture) begin
        idx_q <= '0;
      end else if (load_out) begin
        idx_q <= (idx_q == LastBin) ? '0 : idx_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      num_q     <= sum_q * MeanScale;
      den_q     <= den_full[15:0];
      den_pos_q <= den_pos;
    end
    if (state_q == BS_MUL) begin
      mean_q       <= 32'd0;
      mean_valid_q <= den_pos_q;
    end else if (div_done) begin
      mean_q <= div_quo;
    end
    if (load_out) begin
      out_mean_q       <= mean_q;
      out_mean_valid_q <= mean_valid_q;
      out_count_q      <= count_q;
      out_idx_q        <= 5'(idx_q);
      out_bin_q        <= bins_q[idx_q];
      out_last_q       <= (idx_q == LastBin);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mean_x100_o    = out_mean_q;
  assign mean_valid_o   = out_mean_valid_q;
  assign sample_count_o = out_count_q;
  assign bin_index_o    = out_idx_q;
  assign bin_count_o    = out_bin_q;
  assign last_o         = out_last_q;

  `ARSC_ASSERT(a_div_only_in_div, div_busy |-> state_q == BS_DIV, "divider busy outside divide")
  `ARSC_ASSERT(a_record_counts, (rec && !clear) |=> count_q == $past(count_q) + 16'd1, "count lost")
  `ARSC_NEVER(a_idx_range, idx_q > LastBin, "bin index out of range")
  `ARSC_NEVER(a_mean_den, state_q == BS_EMIT && mean_valid_q && den_q == 16'd0, "valid mean on zero")

endmodule

`default_nettype wire

// ===== hdl/ascii_reading_stats_collector_top.sv =====
// byte request: one per cycle while the command queue has room
// read request: once it leaves the queue, multiply, then the 32-step divider if the mean is valid,
// then one result per cycle as taken, 20 results in all
// the serial divider and the bin walk set the read cost; the queue holds 2 commands
// reset (rst_ni low, async) clears header match, digits, queue, sum, count and all bins
`default_nettype none

module ascii_reading_stats_collector_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] mean_x100_o,
  output logic        mean_valid_o,
  output logic [15:0] sample_count_o,
  output logic [4:0]  bin_index_o,
  output logic [7:0]  bin_count_o,
  output logic        last_o
);
  import arsc_pkg::*;

  logic fq_valid, fq_ready, qb_valid, qb_ready;
  cmd_t fq_cmd, qb_cmd;

  arsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .rx_byte_i   (rx_byte_i),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_o       (fq_cmd)
  );

  arsc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_i       (fq_cmd),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_o        (qb_cmd)
  );

  arsc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (qb_valid),
    .cmd_ready_o    (qb_ready),
    .cmd_i          (qb_cmd),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .mean_x100_o    (mean_x100_o),
    .mean_valid_o   (mean_valid_o),
    .sample_count_o (sample_count_o),
    .bin_index_o    (bin_index_o),
    .bin_count_o    (bin_count_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire
